FILE: design/bbst_pkg.sv
// Shared constants, types and helper functions of the bad-block skip translator.
package bbst_pkg;

    // Flash geometry.
    localparam int BLOCKS         = 1024;
    localparam int PAGES_IN_BLOCK = 64;
    localparam int BYTES_IN_PAGE  = 2048;
    localparam longint BLOCK_BYTES = longint'(PAGES_IN_BLOCK) * longint'(BYTES_IN_PAGE);

    // Bitmap layout.
    localparam int WORD_BITS      = 32;
    localparam int WORD_BITS_LOG2 = 5;
    localparam int MAP_WORDS      = (BLOCKS + WORD_BITS - 1) >> WORD_BITS_LOG2;
    localparam int WIDX_W         = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int NIB_W          = 3;
    localparam int PHYS_W         = WIDX_W + WORD_BITS_LOG2;
    localparam int TAIL_BITS      = BLOCKS % WORD_BITS;
    localparam logic [WORD_BITS-1:0] ALL_GOOD  = 32'hFFFF_FFFF;
    localparam logic [WORD_BITS-1:0] TAIL_MASK =
        (TAIL_BITS == 0) ? ALL_GOOD : ((32'h1 << TAIL_BITS) - 32'h1);

    // Field widths.
    localparam int KIND_W  = 2;
    localparam int ADDR_W  = 27;
    localparam int INDEX_W = 5;
    localparam int DATA_W  = 32;
    localparam int BLOCK_W = 10;
    localparam int PROD_W  = 64;
    localparam int CNT_W   = 6;

    // Request kinds.
    localparam logic [KIND_W-1:0] KIND_TRANSLATE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_MARK      = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LOAD      = 2'd2;

    typedef struct packed {
        logic [ADDR_W-1:0]  physical_address;
        logic [BLOCK_W-1:0] physical_block;
        logic               status;
    } result_t;

    typedef struct packed {
        logic                 we;
        logic [WIDX_W-1:0]    waddr;
        logic [DATA_W-1:0]    wdata;
        logic                 re;
        logic [WIDX_W-1:0]    raddr;
    } ram_req_t;

    // Bits of a bitmap word that stand for blocks that exist.
    function automatic logic [WORD_BITS-1:0] live_mask(input logic [WIDX_W-1:0] w);
        return (w == WIDX_W'(MAP_WORDS - 1)) ? TAIL_MASK : ALL_GOOD;
    endfunction

    function automatic logic [CNT_W-1:0] ones32(input logic [WORD_BITS-1:0] v);
        logic [CNT_W-1:0] n;
        n = '0;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            n = n + CNT_W'(v[i]);
        end
        return n;
    endfunction

    function automatic logic [2:0] ones4(input logic [3:0] v);
        return 3'(v[0]) + 3'(v[1]) + 3'(v[2]) + 3'(v[3]);
    endfunction

endpackage

FILE: design/bbst_in_if.sv
// Request channel of the bad-block skip translator.
interface bbst_in_if;
    import bbst_pkg::*;

    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [ADDR_W-1:0]   address;
    logic [INDEX_W-1:0]  word_index;
    logic [DATA_W-1:0]   word_data;

    modport source (output valid, kind, address, word_index, word_data, input ready);
    modport sink   (input valid, kind, address, word_index, word_data, output ready);
endinterface

FILE: design/bbst_out_if.sv
// Result channel of the bad-block skip translator.
interface bbst_out_if;
    import bbst_pkg::*;

    logic                valid;
    logic                ready;
    logic [ADDR_W-1:0]   physical_address;
    logic [BLOCK_W-1:0]  physical_block;
    logic                status;

    modport source (output valid, physical_address, physical_block, status, input ready);
    modport sink   (input valid, physical_address, physical_block, status, output ready);
endinterface

FILE: design/bbst_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module bbst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

FILE: design/bbst_ctrl.sv
// Request sequencer: table load, bitmap word sweep, bit scan within the hit word and write-back.
module bbst_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    bbst_in_if.sink               req,
    output bbst_pkg::ram_req_t    ram_req,
    input  logic [bbst_pkg::DATA_W-1:0] ram_rdata,
    output bbst_pkg::result_t     res,
    output logic                  res_valid,
    input  logic                  res_take
);
    import bbst_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SWEEP = 5'b00010,
        ST_SCAN  = 5'b00100,
        ST_MARK  = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t               state_reg, state_next;
    logic [KIND_W-1:0]    kind_reg, kind_next;
    logic [ADDR_W-1:0]    remaining_reg, remaining_next;
    logic [ADDR_W-1:0]    offset_reg, offset_next;
    logic [WIDX_W:0]      issue_reg, issue_next;
    logic                 pend_reg, pend_next;
    logic [WIDX_W-1:0]    pend_word_reg, pend_word_next;
    logic [DATA_W-1:0]    word_reg, word_next;
    logic [DATA_W-1:0]    scan_reg, scan_next;
    logic [NIB_W-1:0]     nib_reg, nib_next;
    logic [WIDX_W-1:0]    widx_reg, widx_next;
    logic [PHYS_W-1:0]    phys_reg, phys_next;
    logic                 hit_reg, hit_next;
    logic                 status_reg, status_next;
    logic [MAP_WORDS-1:0] valid_reg, valid_next;

    logic [DATA_W-1:0]    eff_word;
    logic [DATA_W-1:0]    live_word;
    logic [CNT_W-1:0]     word_ones;
    logic [2:0]           nib_ones;
    logic [1:0]           nib_pos;
    logic [1:0]           skip;
    logic                 pos_found;
    logic [PROD_W-1:0]    prod;

    // A word never written since reset reads as all good.
    assign eff_word  = valid_reg[pend_word_reg] ? ram_rdata : ALL_GOOD;
    assign live_word = eff_word & live_mask(pend_word_reg);
    assign word_ones = ones32(live_word);
    assign nib_ones  = ones4(scan_reg[3:0]);

    // Position of the set bit within the current nibble that the remaining count selects.
    always_comb
    begin
        skip      = remaining_reg[1:0];
        nib_pos   = '0;
        pos_found = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            if (scan_reg[i] && !pos_found)
            begin
                if (skip == 2'd0)
                begin
                    nib_pos   = 2'(i);
                    pos_found = 1'b1;
                end
                else
                begin
                    skip = skip - 2'd1;
                end
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        remaining_next = remaining_reg;
        offset_next    = offset_reg;
        issue_next     = issue_reg;
        pend_next      = 1'b0;
        pend_word_next = pend_word_reg;
        word_next      = word_reg;
        scan_next      = scan_reg;
        nib_next       = nib_reg;
        widx_next      = widx_reg;
        phys_next      = phys_reg;
        hit_next       = hit_reg;
        status_next    = status_reg;
        valid_next     = valid_reg;
        ram_req        = '0;
        req.ready      = 1'b0;
        res_valid      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    kind_next      = req.kind;
                    hit_next       = 1'b0;
                    status_next    = 1'b0;
                    remaining_next = ADDR_W'(longint'(req.address) / BLOCK_BYTES);
                    offset_next    = ADDR_W'(longint'(req.address) % BLOCK_BYTES);
                    issue_next     = '0;
                    state_next     = ST_DONE;
                    if (req.kind == KIND_TRANSLATE || req.kind == KIND_MARK)
                    begin
                        state_next = ST_SWEEP;
                    end
                    else if (req.kind == KIND_LOAD)
                    begin
                        if (32'(req.word_index) < 32'(MAP_WORDS))
                        begin
                            ram_req.we    = 1'b1;
                            ram_req.waddr = WIDX_W'(req.word_index);
                            ram_req.wdata = req.word_data;
                            valid_next[WIDX_W'(req.word_index)] = 1'b1;
                        end
                    end
                end
            end

            ST_SWEEP:
            begin
                // Reads run one word ahead of the count that checks them.
                if (issue_reg < (WIDX_W + 1)'(MAP_WORDS))
                begin
                    ram_req.re     = 1'b1;
                    ram_req.raddr  = issue_reg[WIDX_W-1:0];
                    issue_next     = issue_reg + (WIDX_W + 1)'(1);
                    pend_next      = 1'b1;
                    pend_word_next = issue_reg[WIDX_W-1:0];
                end
                if (pend_reg)
                begin
                    if (remaining_reg < ADDR_W'(word_ones))
                    begin
                        word_next  = eff_word;
                        scan_next  = live_word;
                        widx_next  = pend_word_reg;
                        nib_next   = '0;
                        pend_next  = 1'b0;
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        remaining_next = remaining_reg - ADDR_W'(word_ones);
                        if (pend_word_reg == WIDX_W'(MAP_WORDS - 1))
                        begin
                            status_next = 1'b1;
                            state_next  = ST_DONE;
                        end
                    end
                end
            end

            ST_SCAN:
            begin
                if (remaining_reg < ADDR_W'(nib_ones))
                begin
                    phys_next  = {widx_reg, nib_reg, nib_pos};
                    hit_next   = 1'b1;
                    state_next = (kind_reg == KIND_MARK) ? ST_MARK : ST_DONE;
                end
                else
                begin
                    remaining_next = remaining_reg - ADDR_W'(nib_ones);
                    scan_next      = scan_reg >> 4;
                    nib_next       = nib_reg + NIB_W'(1);
                end
            end

            ST_MARK:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = widx_reg;
                ram_req.wdata = word_reg & ~(32'h1 << phys_reg[WORD_BITS_LOG2-1:0]);
                valid_next[widx_reg] = 1'b1;
                state_next    = ST_DONE;
            end

            ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign prod = PROD_W'(phys_reg) * PROD_W'(BLOCK_BYTES) + PROD_W'(offset_reg);

    always_comb
    begin
        res = '0;
        res.status = status_reg;
        if (hit_reg)
        begin
            res.physical_address = prod[ADDR_W-1:0];
            res.physical_block   = BLOCK_W'(phys_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pend_reg  <= 1'b0;
            valid_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg      <= kind_next;
        remaining_reg <= remaining_next;
        offset_reg    <= offset_next;
        issue_reg     <= issue_next;
        pend_word_reg <= pend_word_next;
        word_reg      <= word_next;
        scan_reg      <= scan_next;
        nib_reg       <= nib_next;
        widx_reg      <= widx_next;
        phys_reg      <= phys_next;
        hit_reg       <= hit_next;
        status_reg    <= status_next;
    end
endmodule

FILE: design/bad_block_skip_translator_core.sv
// From the accepting edge to the edge that loads the output register: a load or unused
// request goes straight to the result; a translate reads one bitmap word per cycle from
// the map RAM, then scans one nibble per cycle in the hit word; a mark bad then writes
// the word back. Requests are taken one at a time; the controller waits while the output
// register stays full.
// Reset clears the controller and the per-word valid bits, so the whole map reads as good.
module bad_block_skip_translator_core (
    input  logic       clk,
    input  logic       rst_n,
    bbst_in_if.sink    req,
    bbst_out_if.source rsp
);
    import bbst_pkg::*;

    ram_req_t          ram_req;
    logic [DATA_W-1:0] ram_rdata;
    result_t           res;
    logic              res_valid;
    logic              res_take;
    logic              out_valid_reg, out_valid_next;
    result_t           out_res_reg, out_res_next;

    bbst_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAP_WORDS)
    ) u_map (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .re    (ram_req.re),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

    bbst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata),
        .res       (res),
        .res_valid (res_valid),
        .res_take  (res_take)
    );

    // The output register frees the controller as soon as it holds the result.
    assign res_take = res_valid && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (res_take)
        begin
            out_valid_next = 1'b1;
            out_res_next   = res;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    assign rsp.valid            = out_valid_reg;
    assign rsp.physical_address = out_res_reg.physical_address;
    assign rsp.physical_block   = out_res_reg.physical_block;
    assign rsp.status           = out_res_reg.status;

`ifndef SYNTHESIS
    a_take_shows: assert property (@(posedge clk) disable iff (!rst_n)
        res_take |=> rsp.valid)
        else $error("result taken by the output register but not presented");

    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        ram_req.we |-> !ram_req.re)
        else $error("map RAM written and read in the same cycle");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status |-> rsp.physical_address == '0 && rsp.physical_block == '0)
        else $error("out-of-range result carries a non-zero address or block");

    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |-> !res_valid && !ram_req.re)
        else $error("request accepted while the sequencer is busy");
`endif
endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the bad-block skip translator core.
module testbench;
    import bbst_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int  IDLE_MAX    = 9;
    localparam int  QUIET_LIMIT = 2000;
    localparam int  TAIL_CYCLES = 64;
    localparam int  RANDOM_ITEMS = 1250;
    localparam int  LOGICAL_MAX = int'((longint'(1) << ADDR_W) / BLOCK_BYTES) - 1;

    logic clk;
    logic rst_n;

    bbst_in_if  req_ch ();
    bbst_out_if rsp_ch ();

    bad_block_skip_translator_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Own copy of the good-block bitmap, kept in request order.
    logic [WORD_BITS-1:0] good_map [MAP_WORDS];
    result_t pending_lookups [$];

    int  mismatch_count = 0;
    int  quiet_cycles   = 0;
    bit  no_idle        = 1'b0;
    int  table_density  = 0;
    int  n_translate    = 0;
    int  n_mark         = 0;
    int  n_load         = 0;
    int  n_unused       = 0;
    int  n_out_of_range = 0;
    int  n_checked      = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int draw_idle();
        return no_idle ? 0 : $urandom_range(0, IDLE_MAX);
    endfunction

    // Bits of word w that stand for blocks which exist.
    function automatic logic [WORD_BITS-1:0] usable_bits(input int w);
        int left;
        left = BLOCKS - w * WORD_BITS;
        if (left >= WORD_BITS)
            return '1;
        return (32'h1 << left) - 32'h1;
    endfunction

    function automatic int good_total();
        int n;
        n = 0;
        for (int w = 0; w < MAP_WORDS; w++)
            n += $countones(good_map[w] & usable_bits(w));
        return n;
    endfunction

    function automatic result_t predict_lookup(input logic [KIND_W-1:0] kind,
                                               input logic [ADDR_W-1:0] addr,
                                               input logic [INDEX_W-1:0] idx,
                                               input logic [DATA_W-1:0] data);
        result_t              outcome;
        longint               logical;
        longint               offset;
        longint               remaining;
        longint               phys_addr;
        int                   phys;
        bit                   found;
        logic [WORD_BITS-1:0] word;
        outcome = '0;
        found   = 1'b0;
        phys    = 0;
        if (kind == KIND_TRANSLATE || kind == KIND_MARK)
        begin
            logical   = longint'(addr) / BLOCK_BYTES;
            offset    = longint'(addr) % BLOCK_BYTES;
            remaining = logical;
            for (int w = 0; w < MAP_WORDS; w++)
            begin
                word = good_map[w] & usable_bits(w);
                if (!found && remaining < $countones(word))
                begin
                    for (int b = 0; b < WORD_BITS; b++)
                    begin
                        if (!found && word[b])
                        begin
                            if (remaining == 0)
                            begin
                                found = 1'b1;
                                phys  = w * WORD_BITS + b;
                            end
                            else
                            begin
                                remaining--;
                            end
                        end
                    end
                end
                else if (!found)
                begin
                    remaining -= $countones(word);
                end
            end
            if (found)
            begin
                phys_addr = longint'(phys) * BLOCK_BYTES + offset;
                outcome.physical_address = phys_addr[ADDR_W-1:0];
                outcome.physical_block   = phys[BLOCK_W-1:0];
                // The result is the mapping seen before the block is retired.
                if (kind == KIND_MARK)
                    good_map[phys / WORD_BITS][phys % WORD_BITS] = 1'b0;
            end
            else
            begin
                outcome.status = 1'b1;
            end
        end
        else if (kind == KIND_LOAD)
        begin
            if (int'(idx) < MAP_WORDS)
                good_map[idx] = data;
        end
        return outcome;
    endfunction

    function automatic logic [ADDR_W-1:0] block_address(input int logical, input longint offset);
        longint full;
        full = longint'(logical) * BLOCK_BYTES + offset;
        return full[ADDR_W-1:0];
    endfunction

    function automatic longint random_offset();
        return longint'($urandom) % BLOCK_BYTES;
    endfunction

    // A logical address that is mostly within the good blocks left.
    function automatic logic [ADDR_W-1:0] pick_address();
        int total;
        int logical;
        total = good_total();
        if (total == 0)
            logical = $urandom_range(0, LOGICAL_MAX);
        else
            logical = $urandom_range(0, total - 1);
        return block_address(logical, random_offset());
    endfunction

    function automatic logic [DATA_W-1:0] random_table_word();
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic [DATA_W-1:0] c;
        a = $urandom;
        b = $urandom;
        c = $urandom;
        case (table_density)
            0: return '1;
            1: return a;
            2: return a & b & c;
            3: return a | b;
            default: return ($urandom_range(0, 7) == 0) ? '0 : a;
        endcase
    endfunction

    task automatic send_request(input logic [KIND_W-1:0] kind, input logic [ADDR_W-1:0] addr,
                                input logic [INDEX_W-1:0] idx, input logic [DATA_W-1:0] data);
        int      gap;
        result_t outcome;
        gap = draw_idle();
        @(negedge clk);
        if (gap > 0)
        begin
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.kind       = kind;
        req_ch.address    = addr;
        req_ch.word_index = idx;
        req_ch.word_data  = data;
        req_ch.valid      = 1'b1;
        do @(posedge clk); while (req_ch.ready !== 1'b1);
        outcome = predict_lookup(kind, addr, idx, data);
        pending_lookups.push_back(outcome);
        case (kind)
            KIND_TRANSLATE: n_translate++;
            KIND_MARK:      n_mark++;
            KIND_LOAD:      n_load++;
            default:        n_unused++;
        endcase
        if (outcome.status)
            n_out_of_range++;
    endtask

    // Translate or mark with unrelated table fields left random.
    task automatic send_lookup(input logic [KIND_W-1:0] kind, input logic [ADDR_W-1:0] addr);
        send_request(kind, addr, INDEX_W'($urandom), $urandom);
    endtask

    // Drops valid after the last accepted request so that nothing is taken twice.
    task automatic release_request();
        @(negedge clk);
        req_ch.valid = 1'b0;
    endtask

    task automatic send_random_request();
        int pick;
        int total;
        int logical;
        pick = $urandom_range(0, 99);
        if (pick < 50)
        begin
            send_lookup(KIND_TRANSLATE, pick_address());
        end
        else if (pick < 75)
        begin
            send_lookup(KIND_MARK, pick_address());
        end
        else if (pick < 85)
        begin
            send_request(KIND_LOAD, ADDR_W'($urandom), INDEX_W'($urandom), random_table_word());
        end
        else if (pick < 92)
        begin
            send_lookup($urandom_range(0, 1) ? KIND_MARK : KIND_TRANSLATE, ADDR_W'($urandom));
        end
        else if (pick < 96)
        begin
            send_request(KIND_UNUSED, ADDR_W'($urandom), INDEX_W'($urandom), $urandom);
        end
        else
        begin
            // Right at the edge of the good blocks: the last one, or the first beyond.
            total   = good_total();
            logical = (total > 0 && $urandom_range(0, 1)) ? total - 1 : total;
            if (logical > LOGICAL_MAX)
                logical = LOGICAL_MAX;
            send_lookup(KIND_TRANSLATE, block_address(logical, random_offset()));
        end
    endtask

    task automatic test_directed();
        send_lookup(KIND_TRANSLATE, '0);
        send_lookup(KIND_TRANSLATE, '1);
        send_lookup(KIND_MARK, '0);
        send_lookup(KIND_TRANSLATE, '0);
        send_lookup(KIND_TRANSLATE, block_address(0, BLOCK_BYTES - 1));
        send_lookup(KIND_MARK, block_address(0, 5));
        // With the last word cleared, the top logical block has nothing to map onto.
        send_request(KIND_LOAD, '0, INDEX_W'(MAP_WORDS - 1), '0);
        send_lookup(KIND_TRANSLATE, '1);
        send_lookup(KIND_MARK, '1);
        send_request(KIND_LOAD, '1, '0, 32'hAAAA_AAAA);
        send_lookup(KIND_TRANSLATE, block_address(5, random_offset()));
        send_request(KIND_LOAD, '0, INDEX_W'(1), 32'h8000_0000);
        send_lookup(KIND_TRANSLATE, block_address(16, random_offset()));
        send_request(KIND_UNUSED, '1, '1, '1);
        send_request(KIND_UNUSED, '0, '0, '0);
        send_request(KIND_LOAD, '0, '0, '1);
        send_request(KIND_LOAD, '0, INDEX_W'(1), '1);
        send_request(KIND_LOAD, '0, '1, '1);
        send_lookup(KIND_TRANSLATE, '1);
        send_request(KIND_LOAD, '0, INDEX_W'(16), 32'h0000_0001);
        send_lookup(KIND_TRANSLATE, block_address(16 * WORD_BITS, random_offset()));
        send_lookup(KIND_TRANSLATE, block_address(16 * WORD_BITS + 1, random_offset()));
        send_request(KIND_LOAD, '0, INDEX_W'(16), '1);
    endtask

    task automatic test_random_tables();
        int issued;
        issued = 0;
        while (issued < RANDOM_ITEMS)
        begin
            table_density = $urandom_range(0, 4);
            if ($urandom_range(0, 3) == 0)
            begin
                for (int w = 0; w < MAP_WORDS; w++)
                    send_request(KIND_LOAD, ADDR_W'($urandom), INDEX_W'(w), random_table_word());
                issued += MAP_WORDS;
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                begin
                    send_request(KIND_LOAD, ADDR_W'($urandom), INDEX_W'($urandom),
                                 random_table_word());
                    issued++;
                end
            end
            repeat ($urandom_range(20, 50))
            begin
                send_random_request();
                issued++;
            end
        end
    endtask

    task automatic test_back_to_back();
        no_idle = 1'b1;
        repeat (80) send_random_request();
        no_idle = 1'b0;
    endtask

    task automatic test_drain_pause();
        repeat (3)
        begin
            repeat (15) send_random_request();
            release_request();
            while (pending_lookups.size() != 0) @(posedge clk);
        end
    endtask

    initial
    begin : result_checker
        result_t want;
        int      stall;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            stall = draw_idle();
            if (stall > 0)
            begin
                rsp_ch.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp_ch.ready = 1'b1;
            do @(posedge clk); while (rsp_ch.valid !== 1'b1);
            if (pending_lookups.size() == 0)
            begin
                $display("%0t: unexpected result addr %h block %h status %b", $time,
                         rsp_ch.physical_address, rsp_ch.physical_block, rsp_ch.status);
                mismatch_count++;
            end
            else
            begin
                want = pending_lookups.pop_front();
                n_checked++;
                if (rsp_ch.physical_address !== want.physical_address)
                begin
                    $display("%0t: physical_address expected %h got %h", $time,
                             want.physical_address, rsp_ch.physical_address);
                    mismatch_count++;
                end
                if (rsp_ch.physical_block !== want.physical_block)
                begin
                    $display("%0t: physical_block expected %0d got %0d", $time,
                             want.physical_block, rsp_ch.physical_block);
                    mismatch_count++;
                end
                if (rsp_ch.status !== want.status)
                begin
                    $display("%0t: status expected %b got %b", $time,
                             want.status, rsp_ch.status);
                    mismatch_count++;
                end
            end
        end
    end

    // Ends the run if the block stops moving requests or results altogether.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            begin
                quiet_cycles <= 0;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
                if (quiet_cycles >= QUIET_LIMIT)
                begin
                    $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                             $time, QUIET_LIMIT, pending_lookups.size());
                    $display("TB_ERROR");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        req_ch.valid      = 1'b0;
        req_ch.kind       = KIND_TRANSLATE;
        req_ch.address    = '0;
        req_ch.word_index = '0;
        req_ch.word_data  = '0;
        rst_n             = 1'b0;
        for (int w = 0; w < MAP_WORDS; w++)
            good_map[w] = ALL_GOOD;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random_tables();
        test_back_to_back();
        test_drain_pause();

        release_request();
        while (pending_lookups.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d translations, %0d mark-bad and %0d table loads, %0d unused kinds.",
                 n_translate, n_mark, n_load, n_unused);
        $display("%0d results checked, %0d of them past the last good block, %0d mismatches.",
                 n_checked, n_out_of_range, mismatch_count);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: bad_block_skip_translator_core.f
design/bbst_pkg.sv
design/bbst_in_if.sv
design/bbst_out_if.sv
design/bbst_ram.sv
design/bbst_ctrl.sv
design/bad_block_skip_translator_core.sv
tb/testbench.sv
